### rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants and controller/datapath handshake types for the timer
// slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int OPCODE_W   = 2;
    localparam int SLOT_ID_W  = 4;
    localparam int INTERVAL_W = 31;
    localparam int TIME_W     = 32;

    localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CANCEL   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic sched;       // write slot from the input beat
        logic cancel;      // clear active mark of the addressed slot
        logic tick_start;  // latch now, rewind the scan pointer
        logic scan_en;     // advance the read / evaluate pipeline
        logic flush;       // move the pending expiry to the output as last
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic issue_done;  // every slot has been read
        logic ev_valid;    // evaluate stage holds a slot
        logic ev_fire;     // that slot expires on this tick
        logic pend_valid;  // one expiry waits for its last flag
        logic out_free;    // output register can take a beat this cycle
    } t_status;

endpackage

`default_nettype wire

### rtl/core/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer for the timer slot table: takes input beats when idle, runs the
// slot scan of a tick and the final flush of the pending expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl
    import stt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    output logic                     o_in_stall,
    input  wire t_status             i_status,
    output t_cmd                     o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       hold;

    assign o_in_stall = (r_state != S_IDLE);

    // a new expiry needs the output when one is already pending
    assign hold = i_status.ev_fire && i_status.pend_valid && !i_status.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.sched      = (i_opcode == OP_SCHEDULE);
                    o_cmd.cancel     = (i_opcode == OP_CANCEL);
                    o_cmd.tick_start = (i_opcode == OP_TICK);
                    if (i_opcode == OP_TICK) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = !hold;
                if (i_status.issue_done && !i_status.ev_valid) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stt_dpath.sv
// ----------------------------------------------------------------------------
// stt_dpath
// Slot storage, scan pipeline (read, then evaluate), pending expiry and
// output register of the timer slot table.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dpath
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [SLOT_ID_W-1:0]  i_slot_id,
    input  wire logic [INTERVAL_W-1:0] i_interval_ms,
    input  wire logic                  i_repeat_flag,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [SLOT_ID_W-1:0]       o_fired_slot,
    output logic                       o_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // slot storage: interval with repeat mark on top, and due time
    logic [INTERVAL_W:0]   ivl_mem [NUM_SLOTS];
    logic [TIME_W-1:0]     due_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_active;

    logic [TIME_W-1:0]     r_now;
    logic [CW-1:0]         r_rd_idx;
    logic                  r_ev_valid;
    logic [IW-1:0]         r_ev_idx;
    logic [INTERVAL_W:0]   r_ivl_q;
    logic [TIME_W-1:0]     r_due_q;

    logic                  r_pend_valid;
    logic [SLOT_ID_W-1:0]  r_pend_slot;
    logic                  r_out_valid;
    logic [SLOT_ID_W-1:0]  r_out_slot;
    logic                  r_out_last;

    logic [31:0]           id_ext;
    logic                  id_ok;
    logic [IW-1:0]         id_addr;
    logic [31:0]           ev_ext;
    logic [SLOT_ID_W-1:0]  ev_slot;
    logic                  issue_done;
    logic [TIME_W-1:0]     diff;
    logic                  ev_fire;
    logic                  ev_rep;
    logic                  rearm;
    logic                  due_we;
    logic [IW-1:0]         due_wa;
    logic [TIME_W-1:0]     due_wd;
    logic                  out_free;
    logic                  pass_pend;

    assign id_ext  = 32'(i_slot_id);
    assign id_ok   = (id_ext < 32'(NUM_SLOTS));
    assign id_addr = id_ext[IW-1:0];

    assign ev_ext  = 32'(r_ev_idx);
    assign ev_slot = ev_ext[SLOT_ID_W-1:0];

    assign issue_done = (r_rd_idx == CW'(NUM_SLOTS));

    // wrap-aware: reached when now - due is not negative
    assign diff    = r_now - r_due_q;
    assign ev_fire = r_ev_valid && r_active[r_ev_idx] && !diff[TIME_W-1];
    assign ev_rep  = r_ivl_q[INTERVAL_W];
    assign rearm   = i_cmd.scan_en && ev_fire && ev_rep;

    assign due_we = (i_cmd.sched && id_ok) || rearm;
    assign due_wa = i_cmd.sched ? id_addr : r_ev_idx;
    assign due_wd = i_cmd.sched ? (i_now_ms + TIME_W'(i_interval_ms))
                                : (r_now + TIME_W'(r_ivl_q[INTERVAL_W-1:0]));

    assign out_free  = !r_out_valid || !i_out_stall;
    assign pass_pend = i_cmd.scan_en && ev_fire && r_pend_valid;

    assign o_status.issue_done = issue_done;
    assign o_status.ev_valid   = r_ev_valid;
    assign o_status.ev_fire    = ev_fire;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_fired_slot = r_out_slot;
    assign o_last       = r_out_last;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.sched && id_ok) begin
            ivl_mem[id_addr] <= {i_repeat_flag, i_interval_ms};
        end
        if (i_cmd.scan_en && !issue_done) begin
            r_ivl_q <= ivl_mem[r_rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (due_we) begin
            due_mem[due_wa] <= due_wd;
        end
        if (i_cmd.scan_en && !issue_done) begin
            r_due_q <= due_mem[r_rd_idx[IW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_now <= i_now_ms;
        end
        if (i_cmd.scan_en && !issue_done) begin
            r_ev_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.scan_en && ev_fire) begin
            r_pend_slot <= ev_slot;
        end
        if (pass_pend) begin
            r_out_slot <= r_pend_slot;
            r_out_last <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_slot <= r_pend_slot;
            r_out_last <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_rd_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sched && id_ok) begin
                r_active[id_addr] <= 1'b1;
            end else if (i_cmd.cancel && id_ok) begin
                r_active[id_addr] <= 1'b0;
            end else if (i_cmd.scan_en && ev_fire && !ev_rep) begin
                r_active[r_ev_idx] <= 1'b0;
            end

            if (i_cmd.tick_start) begin
                r_rd_idx   <= '0;
                r_ev_valid <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_ev_valid <= !issue_done;
                if (!issue_done) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end

            if (i_cmd.scan_en && ev_fire) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end

            if (pass_pend || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/software_timer_slot_table_core.sv
// ----------------------------------------------------------------------------
// software_timer_slot_table_core
// Table of timer slots driven by schedule, cancel and tick commands.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one command per beat:
// schedule arms a slot with interval, due time and repeat flag, cancel
// disarms it, tick passes the current millisecond count. Ids at or beyond
// NUM_SLOTS are dropped. Output channel (o_out_valid / i_out_stall) carries
// one beat per expired slot, in ascending slot order, with o_last set on the
// final expiry of the tick. A tick with nothing due produces no beat.
// Schedule and cancel do not stall the input; the next beat may follow at once.
// A tick reads one slot per cycle, unless a stalled output holds the scan,
// through a single read port of the slot storage; the input stalls from
// the tick beat until scan and flush end, longer while a stalled output
// holds them. An expiry waits until the next (or the scan end) sets last.
// Reset clears all active marks, the scan and the output; the stored
// intervals and due times are not cleared and need no clearing pass.
// While the receiver stalls, the output beat holds; the scan pauses only
// when it finds another expiry with one already pending.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_slot_table_core
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OPCODE_W-1:0]   i_opcode,
    input  wire logic [SLOT_ID_W-1:0]  i_slot_id,
    input  wire logic [INTERVAL_W-1:0] i_interval_ms,
    input  wire logic                  i_repeat_flag,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [SLOT_ID_W-1:0]       o_fired_slot,
    output logic                       o_last
);

    t_cmd    cmd;
    t_status status;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stt_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_slot_id     (i_slot_id),
        .i_interval_ms (i_interval_ms),
        .i_repeat_flag (i_repeat_flag),
        .i_now_ms      (i_now_ms),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_fired_slot  (o_fired_slot),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### rtl/core/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker
    import stt_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [OPCODE_W-1:0]  i_opcode,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [SLOT_ID_W-1:0] o_fired_slot,
    input wire logic                 o_last
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_fired_slot) && $stable(o_last))
        else $error("output beat changed under stall");

    // schedule, cancel and unused codes leave the input free to take the next beat
    a_cmd_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode != OP_TICK) |=> !o_in_stall)
        else $error("non-tick command blocked the input");

    // a tick always runs a scan
    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == OP_TICK) |=> o_in_stall)
        else $error("tick did not start a scan");

    // a non-final expiry is only shown while its tick is still in progress
    a_last_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("tick ended without its final expiry");

endmodule

bind software_timer_slot_table_core stt_checker u_stt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_opcode     (i_opcode),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_fired_slot (o_fired_slot),
    .o_last       (o_last)
);

`default_nettype wire
